[src/yuv2rgb_pkg.sv]
// Package for the packed YUV 4:1:1 to RGB converter.
// Holds the Q16 coefficients, widths, mode codes, pixel type and helpers.
// No dependencies.
package yuv2rgb_pkg;

    localparam int BYTE_W = 8;
    localparam int MODE_W = 2;
    localparam int ACC_W  = 26;   // signed Q16 channel sum, covers all byte inputs
    localparam int PIX_W  = 32;
    localparam int DIFF_W = 9;    // signed chroma difference
    localparam int COEF_W = 18;   // coefficient with a zero sign bit

    localparam logic signed [COEF_W-1:0] COEF_RV = 18'sd89831;
    localparam logic signed [COEF_W-1:0] COEF_GV = 18'sd45744;
    localparam logic signed [COEF_W-1:0] COEF_GU = 18'sd22127;
    localparam logic signed [COEF_W-1:0] COEF_BU = 18'sd113538;
    localparam logic [BYTE_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [BYTE_W-1:0] PIX_MAX     = 8'd255;

    // floor(s/3) == (s * 683) >> 11 for every s up to 765
    localparam logic [10:0] RECIP_3       = 11'd683;
    localparam int          RECIP_3_SHIFT = 11;

    localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BGR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BGRA = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_BGR;

    typedef struct packed {
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
    } rgb_t;

    // Truncate toward zero by 2^16, then clamp to 0..255.
    function automatic logic [BYTE_W-1:0] sat_pix(input logic signed [ACC_W-1:0] acc);
        logic [BYTE_W-1:0] res;
        if (acc[ACC_W-1])
            res = '0;
        else if (acc[ACC_W-2])
            res = PIX_MAX;
        else
            res = acc[ACC_W-3:16];
        return res;
    endfunction

    // Pack one pixel in the selected format; unused bytes are zero.
    function automatic logic [PIX_W-1:0] pack_pixel(input logic [MODE_W-1:0] mode,
                                                    input rgb_t px);
        logic [9:0]       sum;
        logic [20:0]      scaled;
        logic [PIX_W-1:0] res;
        sum    = {2'b00, px.r} + {2'b00, px.g} + {2'b00, px.b};
        scaled = {11'd0, sum} * {10'd0, RECIP_3};
        case (mode)
            MODE_GRAY: res = {24'd0, scaled[RECIP_3_SHIFT+7:RECIP_3_SHIFT]};
            MODE_BGRA: res = {PIX_MAX, px.r, px.g, px.b};
            default:   res = {8'd0, px.r, px.g, px.b};
        endcase
        return res;
    endfunction

endpackage

[src/yuv411_packed_to_rgb.sv]
// Top level of the packed YUV 4:1:1 to RGB converter.
// Four-level register pipeline; uses yuv2rgb_pkg for constants and helpers.
//
//  channel | signals                                         | dir
//  --------+-------------------------------------------------+-----
//  input   | in_valid/in_ready, u_sample y_first y_second     | in
//          | v_sample y_third y_fourth (8 bits each)          |
//  output  | out_valid/out_ready, pixel_zero..pixel_three (32)| out
//  config  | cfg_write, cfg_data (output_mode, 2 bits)        | in
//
// One group per clock sustained while the output is not stalled; the accepting
// edge loads the input register, and out_valid rises once the product, channel
// and packing registers have each taken the beat.
// Stages move forward whenever the next one is empty or moving, so a held
// beat at the output stalls only as far back as the pipeline is full.
// Reset clears all stage valid bits and sets output_mode to BGR.
module yuv411_packed_to_rgb (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [yuv2rgb_pkg::MODE_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     u_sample,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     y_first,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     y_second,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     v_sample,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     y_third,
    input  logic [yuv2rgb_pkg::BYTE_W-1:0]     y_fourth,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [yuv2rgb_pkg::PIX_W-1:0]      pixel_zero,
    output logic [yuv2rgb_pkg::PIX_W-1:0]      pixel_one,
    output logic [yuv2rgb_pkg::PIX_W-1:0]      pixel_two,
    output logic [yuv2rgb_pkg::PIX_W-1:0]      pixel_three
);

    localparam int NPIX = 4;
    localparam int BW   = yuv2rgb_pkg::BYTE_W;
    localparam int AW   = yuv2rgb_pkg::ACC_W;
    localparam int PW   = yuv2rgb_pkg::PIX_W;
    localparam int DW   = yuv2rgb_pkg::DIFF_W;
    localparam int CW   = yuv2rgb_pkg::COEF_W;

    // Stage valids and mode register
    logic                 in_vld_reg;
    logic                 prod_vld_reg;
    logic                 rgb_vld_reg;
    logic                 out_vld_reg;
    logic [yuv2rgb_pkg::MODE_W-1:0] mode_reg;

    // Advance enables, computed from the output back
    logic adv_out, adv_rgb, adv_prod, adv_in;

    // Input register: raw group
    logic [BW-1:0]        u_reg, v_reg;
    logic [BW-1:0]        y_in_reg [NPIX];

    // Product register: shared chroma terms plus lumas
    logic signed [AW-1:0] p_rv_reg, p_gv_reg, p_gu_reg, p_bu_reg;
    logic [BW-1:0]        y_prod_reg [NPIX];

    // Channel register: clamped RGB per pixel
    yuv2rgb_pkg::rgb_t    rgb_reg [NPIX];
    yuv2rgb_pkg::rgb_t    rgb_next [NPIX];

    // Output register
    logic [PW-1:0]        pix_reg [NPIX];

    // Chroma products
    logic signed [DW-1:0]      du, dv;
    logic signed [CW+DW-1:0]   m_rv, m_gv, m_gu, m_bu;

    assign adv_out  = !out_vld_reg || out_ready;
    assign adv_rgb  = !rgb_vld_reg || adv_out;
    assign adv_prod = !prod_vld_reg || adv_rgb;
    assign adv_in   = !in_vld_reg || adv_prod;
    assign in_ready = adv_in;

    // Chroma differences, -128..127
    assign du = $signed({1'b0, u_reg}) - $signed({1'b0, yuv2rgb_pkg::CHROMA_BIAS});
    assign dv = $signed({1'b0, v_reg}) - $signed({1'b0, yuv2rgb_pkg::CHROMA_BIAS});

    // One product per coefficient, shared by all four pixels
    assign m_rv = yuv2rgb_pkg::COEF_RV * dv;
    assign m_gv = yuv2rgb_pkg::COEF_GV * dv;
    assign m_gu = yuv2rgb_pkg::COEF_GU * du;
    assign m_bu = yuv2rgb_pkg::COEF_BU * du;

    // Per-pixel channel sums and clamp. Luma goes in at Q16.
    always_comb
    begin
        logic signed [AW-1:0] ys;
        ys = '0;
        for (int i = 0; i < NPIX; i++)
        begin
            ys = $signed({2'b00, y_prod_reg[i], 16'h0000});
            rgb_next[i].r = yuv2rgb_pkg::sat_pix(ys + p_rv_reg);
            rgb_next[i].g = yuv2rgb_pkg::sat_pix(ys - p_gv_reg - p_gu_reg);
            rgb_next[i].b = yuv2rgb_pkg::sat_pix(ys + p_bu_reg);
        end
    end

    // Control: valids and the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            rgb_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            mode_reg     <= yuv2rgb_pkg::MODE_RESET;
        end
        else
        begin
            if (cfg_write)
                mode_reg <= cfg_data;
            if (adv_in)
                in_vld_reg <= in_valid;
            if (adv_prod)
                prod_vld_reg <= in_vld_reg;
            if (adv_rgb)
                rgb_vld_reg <= prod_vld_reg;
            if (adv_out)
                out_vld_reg <= rgb_vld_reg;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            u_reg       <= u_sample;
            v_reg       <= v_sample;
            y_in_reg[0] <= y_first;
            y_in_reg[1] <= y_second;
            y_in_reg[2] <= y_third;
            y_in_reg[3] <= y_fourth;
        end
        if (adv_prod && in_vld_reg)
        begin
            // products fit in 26 bits for byte inputs
            p_rv_reg   <= m_rv[AW-1:0];
            p_gv_reg   <= m_gv[AW-1:0];
            p_gu_reg   <= m_gu[AW-1:0];
            p_bu_reg   <= m_bu[AW-1:0];
            y_prod_reg <= y_in_reg;
        end
        if (adv_rgb && prod_vld_reg)
            rgb_reg <= rgb_next;
        if (adv_out && rgb_vld_reg)
        begin
            for (int i = 0; i < NPIX; i++)
                pix_reg[i] <= yuv2rgb_pkg::pack_pixel(mode_reg, rgb_reg[i]);
        end
    end

    assign out_valid   = out_vld_reg;
    assign pixel_zero  = pix_reg[0];
    assign pixel_one   = pix_reg[1];
    assign pixel_two   = pix_reg[2];
    assign pixel_three = pix_reg[3];

    // An accepted beat lands in the input register
    a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> in_vld_reg)
        else $error("accepted beat not captured");

    // A blocked channel stage keeps its contents
    a_rgb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_vld_reg && !adv_rgb |=> rgb_vld_reg && $stable(rgb_reg[0]) && $stable(rgb_reg[3]))
        else $error("channel stage lost data while stalled");

    // Gray output uses only the low byte
    a_gray_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) && $past(mode_reg) == yuv2rgb_pkg::MODE_GRAY
        |-> pixel_zero[31:8] == 24'd0 && pixel_three[31:8] == 24'd0)
        else $error("gray pixel has nonzero upper bytes");

    // Alpha byte set only in BGRA mode
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) && $past(mode_reg) != yuv2rgb_pkg::MODE_BGRA
        |-> pixel_three[31:24] == 8'd0)
        else $error("alpha byte set outside BGRA mode");

endmodule

[tb/tb_top.sv]
// Self-checking bench for yuv411_packed_to_rgb: corner and random 4:1:1 groups under
// every output mode, bursty input and stalling output, each beat checked by a Q16 predictor.
// Depends on yuv2rgb_pkg (mode codes, widths) and the yuv411_packed_to_rgb RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Bench tuning
    localparam int DRAIN_CYCLES     = 8;     // pipeline is four deep, leave margin
    localparam int IDLE_LIMIT       = 4000;  // cycles without any beat before giving up
    localparam int LONG_HOLD_AT     = 500;   // output beats checked before the long stall
    localparam int LONG_HOLD_CYCLES = 80;

    // Mode value left unused by the package; the block treats it as BGR
    localparam logic [yuv2rgb_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    // Q16 color coefficients, rounded to nearest
    localparam longint Q16_RV = 89831;
    localparam longint Q16_GV = 45744;
    localparam longint Q16_GU = 22127;
    localparam longint Q16_BU = 113538;
    localparam longint CHROMA_MID = 128;
    localparam longint Q16_ONE = 65536;

    typedef logic [yuv2rgb_pkg::BYTE_W-1:0] byte_t;
    typedef logic [yuv2rgb_pkg::MODE_W-1:0] mode_t;
    typedef logic [3:0][yuv2rgb_pkg::PIX_W-1:0] pixel_quad_t;  // [0] is pixel_zero

    typedef struct packed {
        byte_t u;
        byte_t y0;
        byte_t y1;
        byte_t v;
        byte_t y2;
        byte_t y3;
    } yuv_group_t;

    // DUT-facing signals; those the bench drives are known from time zero
    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  cfg_write = 1'b0;
    mode_t cfg_data = '0;
    logic  in_valid = 1'b0;
    logic  in_ready;
    byte_t u_sample = '0;
    byte_t y_first = '0;
    byte_t y_second = '0;
    byte_t v_sample = '0;
    byte_t y_third = '0;
    byte_t y_fourth = '0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    logic [yuv2rgb_pkg::PIX_W-1:0] pixel_zero;
    logic [yuv2rgb_pkg::PIX_W-1:0] pixel_one;
    logic [yuv2rgb_pkg::PIX_W-1:0] pixel_two;
    logic [yuv2rgb_pkg::PIX_W-1:0] pixel_three;

    // Bench state
    mode_t       mode_now = yuv2rgb_pkg::MODE_RESET;  // our copy of output_mode
    yuv_group_t  groups_pending[$];                   // groups not yet put on the bus
    pixel_quad_t pixels_due[$];                       // predicted output beats, oldest first
    int groups_offered  = 0;
    int groups_accepted = 0;
    int groups_checked  = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int hold_left       = 0;
    int style           = 0;
    int style_left      = 0;
    bit long_hold_done  = 1'b0;

    yuv411_packed_to_rgb u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .u_sample    (u_sample),
        .y_first     (y_first),
        .y_second    (y_second),
        .v_sample    (v_sample),
        .y_third     (y_third),
        .y_fourth    (y_fourth),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_zero  (pixel_zero),
        .pixel_one   (pixel_one),
        .pixel_two   (pixel_two),
        .pixel_three (pixel_three)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Color math
    // ------------------------------------------------------------------

    // Q16 sum -> integer, truncating toward zero (SV signed divide does),
    // then saturate to one byte.
    function automatic byte_t clamp_q16(input longint acc);
        longint whole;
        whole = acc / Q16_ONE;
        if (whole < 0)
            return 8'd0;
        if (whole > 255)
            return 8'd255;
        return byte_t'(whole);
    endfunction

    function automatic logic [yuv2rgb_pkg::PIX_W-1:0] yuv_to_packed(input byte_t luma,
                                                                    input longint du,
                                                                    input longint dv,
                                                                    input mode_t mode);
        longint    ys;
        byte_t     r;
        byte_t     g;
        byte_t     b;
        logic [9:0] sum;
        ys  = longint'(luma) * Q16_ONE;
        r   = clamp_q16(ys + Q16_RV * dv);
        g   = clamp_q16(ys - Q16_GV * dv - Q16_GU * du);
        b   = clamp_q16(ys + Q16_BU * du);
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        case (mode)
            yuv2rgb_pkg::MODE_GRAY: return {24'd0, byte_t'(sum / 3)};
            yuv2rgb_pkg::MODE_BGRA: return {8'hFF, r, g, b};
            default:                return {8'h00, r, g, b};  // BGR and the spare code
        endcase
    endfunction

    // All four pixels of a group share its chroma differences
    function automatic pixel_quad_t convert_group(input yuv_group_t grp, input mode_t mode);
        longint      du;
        longint      dv;
        pixel_quad_t quad;
        du      = longint'(grp.u) - CHROMA_MID;
        dv      = longint'(grp.v) - CHROMA_MID;
        quad[0] = yuv_to_packed(grp.y0, du, dv, mode);
        quad[1] = yuv_to_packed(grp.y1, du, dv, mode);
        quad[2] = yuv_to_packed(grp.y2, du, dv, mode);
        quad[3] = yuv_to_packed(grp.y3, du, dv, mode);
        return quad;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic add_group(input byte_t u, input byte_t y0, input byte_t y1,
                             input byte_t v, input byte_t y2, input byte_t y3);
        groups_pending.push_back('{u: u, y0: y0, y1: y1, v: v, y2: y2, y3: y3});
    endtask

    // Bytes lean on the corners: black, white, neutral chroma and its neighbors
    function automatic byte_t pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            3:       return byte_t'($urandom_range(126, 130));
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random(input int count);
        repeat (count)
            add_group(pick_byte(), pick_byte(), pick_byte(),
                      pick_byte(), pick_byte(), pick_byte());
    endtask

    // Sender stays quiet until every group is out and checked, then the
    // pipeline gets a few extra cycles so it is surely empty.
    task automatic drain();
        while (groups_pending.size() != 0 || groups_accepted != groups_offered ||
               pixels_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Only called with the pipeline empty
    task automatic write_mode(input mode_t mode);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= mode;
        @(negedge clk);
        cfg_write <= 1'b0;
        mode_now  = mode;
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps; a gap of
    // zero joins bursts into long back-to-back stretches.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : sender
        yuv_group_t nxt;
        logic       free;
        free = !in_valid || (groups_accepted == groups_offered);
        if (rst_n && free)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (groups_pending.size() > 0)
            begin
                nxt = groups_pending.pop_front();
                u_sample <= nxt.u;
                y_first  <= nxt.y0;
                y_second <= nxt.y1;
                v_sample <= nxt.v;
                y_third  <= nxt.y2;
                y_fourth <= nxt.y3;
                in_valid <= 1'b1;
                groups_offered++;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall style changes at random intervals (always ready,
    // coin flip, mostly ready, mostly stalled). Once, mid-run, it holds off
    // long enough for the pipeline to fill and push back on the input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : receiver
        logic rdy;
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else if (!long_hold_done && groups_checked >= LONG_HOLD_AT)
        begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES - 1;
            rdy            = 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(16, 64);
            end
            style_left--;
            case (style)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 1);
                2:       rdy = ($urandom_range(0, 3) != 0);
                default: rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        out_ready <= rdy;
    end

    // ------------------------------------------------------------------
    // Monitor: checks output beats against the oldest prediction, then
    // predicts for any input beat taken at this edge. Doing both here keeps
    // queue order independent of process scheduling. Also the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pixel_quad_t got;
        pixel_quad_t want;
        logic        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                got   = {pixel_three, pixel_two, pixel_one, pixel_zero};
                if (pixels_due.size() == 0)
                    report_mismatch($sformatf("output beat with nothing pending: %h", got));
                else
                begin
                    want = pixels_due.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got[i] !== want[i])
                            report_mismatch($sformatf("group %0d pixel %0d: got %h, want %h",
                                                      groups_checked, i, got[i], want[i]));
                end
                groups_checked++;
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                pixels_due.push_back(convert_group('{u: u_sample, y0: y_first, y1: y_second,
                                                     v: v_sample, y2: y_third, y3: y_fourth},
                                                   mode_now));
                groups_accepted++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corner groups, left in the reset mode (BGR)
        add_group(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);    // all black
        add_group(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);  // all max
        add_group(8'd128, 8'd0,   8'd1,   8'd128, 8'd254, 8'd255);  // neutral chroma
        add_group(8'd0,   8'd0,   8'd85,  8'd0,   8'd170, 8'd255);  // both chroma min
        add_group(8'd255, 8'd0,   8'd85,  8'd255, 8'd170, 8'd255);  // both chroma max
        add_group(8'd0,   8'd0,   8'd64,  8'd255, 8'd128, 8'd255);  // red up, blue down
        add_group(8'd255, 8'd0,   8'd64,  8'd0,   8'd128, 8'd255);  // blue up, red down
        add_group(8'd127, 8'd0,   8'd1,   8'd129, 8'd2,   8'd3);    // one-step chroma
        add_group(8'd129, 8'd0,   8'd1,   8'd127, 8'd2,   8'd3);
        add_group(8'h55,  8'hAA,  8'h0F,  8'hF0,  8'h33,  8'hCC);   // alternating bits
        add_group(8'd64,  8'd16,  8'd235, 8'd192, 8'd100, 8'd200);
        add_group(8'd192, 8'd16,  8'd235, 8'd64,  8'd100, 8'd200);
        drain();

        // Random phases, one mode each; every mode code written, both ends included
        write_mode(yuv2rgb_pkg::MODE_GRAY);
        add_random(150);
        drain();
        write_mode(yuv2rgb_pkg::MODE_BGRA);
        add_random(150);
        drain();
        write_mode(MODE_SPARE);
        add_random(100);
        drain();
        write_mode(yuv2rgb_pkg::MODE_BGR);   // long output stall lands in this phase
        add_random(200);
        drain();
        write_mode(yuv2rgb_pkg::MODE_GRAY);
        add_random(100);
        drain();
        write_mode(yuv2rgb_pkg::MODE_BGRA);
        add_random(150);
        drain();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
src/yuv2rgb_pkg.sv
src/yuv411_packed_to_rgb.sv
tb/tb_top.sv
